### hw/rtl/fdrb_pkg.sv
// ----------------------------------------------------------------------------
// fdrb_pkg
// types, field layouts and defaults shared by the frame descriptor ring files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdrb_pkg;

  // defaults for the top level parameters
  localparam int SLOTS_DEF      = 16;
  localparam int DATA_BYTES_DEF = 1024 << 10;

  // fixed field widths
  localparam int SIZE_W   = 21;
  localparam int START_W  = 20;
  localparam int META_W   = 134;  // size, ids, frame number, source, video info

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 160;

  // operation carried in the input tuser bit
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // input transfer payload, first field in the highest bits
  typedef struct packed {
    logic [15:0]       width;
    logic [15:0]       height;
    logic              key_frame;
    logic [31:0]       ssrc;
    logic [31:0]       frame_id;
    logic [SIZE_W-1:0] data_size;
    logic [7:0]        stream_id;
    logic [7:0]        media_type;
  } in_item_t;

  // output transfer payload, first field in the highest bits
  typedef struct packed {
    logic [15:0]        out_width;
    logic [15:0]        out_height;
    logic               out_key_frame;
    logic [31:0]        out_ssrc;
    logic [31:0]        out_frame_id;
    logic [SIZE_W-1:0]  out_size;
    logic [7:0]         out_stream_id;
    logic [7:0]         out_media_type;
    logic [START_W-1:0] start_offset;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the input transfer into the item register
    logic do_write;  // commit a write and load its result
    logic do_fail;   // load a rejected result
    logic rd_issue;  // pop the read slot and start the store read
    logic rd_load;   // load the read result from the store data
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_read;
    logic wr_busy;
    logic size_bad;
    logic rd_used;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/fdrb_ram.sv
// ----------------------------------------------------------------------------
// fdrb_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fdrb_ctrl.sv
// ----------------------------------------------------------------------------
// fdrb_ctrl
// sequencer for one descriptor operation at a time, owns the output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdrb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  input  wire fdrb_pkg::status_t sts,
  output fdrb_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_RDWAIT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid;
  logic   out_free;
  logic   load;

  assign out_free = !out_valid || m_tready;
  assign load     = cmd.do_write || cmd.do_fail || cmd.rd_load;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.op_read && sts.rd_used) begin
          cmd.rd_issue = 1'b1;
          state_next   = ST_RDWAIT;
        end else if (out_free) begin
          if (!sts.op_read && !sts.wr_busy && !sts.size_bad) begin
            cmd.do_write = 1'b1;
          end else begin
            cmd.do_fail = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        if (out_free) begin
          cmd.rd_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> out_free)
    else $error("result loaded over a pending transfer");

  // every loaded result is offered next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst) load |=> out_valid)
    else $error("loaded result not offered");

  // valid only rises because of a load
  a_valid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(load))
    else $error("output valid without a result");

endmodule

`default_nettype wire

### hw/rtl/fdrb_datapath.sv
// ----------------------------------------------------------------------------
// fdrb_datapath
// slot pointers, used flags, data space allocator, descriptor store, result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdrb_datapath #(
  parameter int SLOTS      = fdrb_pkg::SLOTS_DEF,
  parameter int DATA_BYTES = fdrb_pkg::DATA_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [fdrb_pkg::IN_TDATA_W-1:0] s_tdata,
  input  wire logic                            s_tuser,
  output logic      [fdrb_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                                 m_tuser,
  input  wire fdrb_pkg::cmd_t                  cmd,
  output fdrb_pkg::status_t                    sts
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int OFF_W  = $clog2(DATA_BYTES + 1);
  localparam int SUM_W  = ((OFF_W > fdrb_pkg::SIZE_W) ? OFF_W : fdrb_pkg::SIZE_W) + 1;
  localparam int WORD_W = OFF_W + fdrb_pkg::META_W;

  fdrb_pkg::in_item_t  item;
  fdrb_pkg::op_t       item_op;
  fdrb_pkg::out_item_t res;
  logic                res_ok;

  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic [OFF_W-1:0]  data_write_offset;
  logic [OFF_W-1:0]  data_write_offset_next;
  logic [SLOTS-1:0]  slot_used;

  logic [SUM_W-1:0]  sum;
  logic              fits;
  logic [OFF_W-1:0]  start;
  logic [SUM_W-1:0]  start_ext;
  logic [SUM_W-1:0]  rd_off_ext;
  logic [WORD_W-1:0] wr_word;
  logic [WORD_W-1:0] rd_word;

  // allocator: place at the current offset unless the frame would reach the end
  assign sum   = SUM_W'(data_write_offset) + SUM_W'(item.data_size);
  assign fits  = sum < SUM_W'(DATA_BYTES);
  assign start = fits ? data_write_offset : '0;
  assign data_write_offset_next = fits ? OFF_W'(sum) : OFF_W'(item.data_size);
  assign start_ext  = SUM_W'(start);
  assign rd_off_ext = SUM_W'(rd_word[OFF_W-1:0]);

  assign sts.op_read  = (item_op == fdrb_pkg::OP_READ);
  assign sts.wr_busy  = slot_used[write_slot];
  assign sts.rd_used  = slot_used[read_slot];
  assign sts.size_bad = SUM_W'(item.data_size) > SUM_W'(DATA_BYTES);

  // store word: video info, source, frame number, ids, size, offset
  assign wr_word = {item.key_frame, item.height, item.width, item.ssrc, item.frame_id,
                    item.media_type, item.stream_id, item.data_size, start};

  fdrb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.do_write),
    .wr_addr (write_slot),
    .wr_data (wr_word),
    .rd_en   (cmd.rd_issue),
    .rd_addr (read_slot),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot        <= '0;
      read_slot         <= '0;
      data_write_offset <= '0;
      slot_used         <= '0;
    end else begin
      if (cmd.do_write) begin
        slot_used[write_slot] <= 1'b1;
        data_write_offset     <= data_write_offset_next;
        write_slot <= (write_slot == SLOT_W'(SLOTS - 1)) ? '0 : write_slot + 1'b1;
      end
      if (cmd.rd_issue) begin
        slot_used[read_slot] <= 1'b0;
        read_slot <= (read_slot == SLOT_W'(SLOTS - 1)) ? '0 : read_slot + 1'b1;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item    <= fdrb_pkg::in_item_t'(s_tdata[$bits(fdrb_pkg::in_item_t)-1:0]);
      item_op <= fdrb_pkg::op_t'(s_tuser);
    end
    if (cmd.do_write) begin
      // start offset sits in the lowest bits, metadata fields stay zero
      res    <= fdrb_pkg::out_item_t'({{($bits(fdrb_pkg::out_item_t) - fdrb_pkg::START_W){1'b0}},
                                       start_ext[fdrb_pkg::START_W-1:0]});
      res_ok <= 1'b1;
    end else if (cmd.do_fail) begin
      res    <= '0;
      res_ok <= 1'b0;
    end else if (cmd.rd_load) begin
      res.start_offset   <= rd_off_ext[fdrb_pkg::START_W-1:0];
      res.out_size       <= rd_word[OFF_W +: 21];
      res.out_stream_id  <= rd_word[OFF_W + 21 +: 8];
      res.out_media_type <= rd_word[OFF_W + 29 +: 8];
      res.out_frame_id   <= rd_word[OFF_W + 37 +: 32];
      res.out_ssrc       <= rd_word[OFF_W + 69 +: 32];
      res.out_width      <= rd_word[OFF_W + 101 +: 16];
      res.out_height     <= rd_word[OFF_W + 117 +: 16];
      res.out_key_frame  <= rd_word[OFF_W + 133];
      res_ok             <= 1'b1;
    end
  end

  assign m_tdata = fdrb_pkg::OUT_TDATA_W'(res);
  assign m_tuser = res_ok;

  // a committed write leaves its slot marked used
  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    cmd.do_write |=> slot_used[$past(write_slot)])
    else $error("written slot not marked used");

  // a pop frees its slot
  a_read_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |=> !slot_used[$past(read_slot)])
    else $error("popped slot still used");

  // the allocator never runs past the end of the data space
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    cmd.do_write |=> (data_write_offset <= OFF_W'(DATA_BYTES)))
    else $error("data offset beyond buffer");

endmodule

`default_nettype wire

### hw/rtl/frame_descriptor_ring_buffer.sv
// ----------------------------------------------------------------------------
// frame_descriptor_ring_buffer
// descriptor ring for frames with a circular data space allocator
// ----------------------------------------------------------------------------
// usage
//   s_* carries one request per transfer: s_tuser is the operation (0 write
//   descriptor, 1 pop oldest), s_tdata the frame metadata. m_* returns one
//   result per request: m_tuser is the ok flag, m_tdata the start offset and,
//   for a pop, the stored metadata (zero on writes and on failures).
//   a write is rejected when the slot under the write pointer is still used
//   or the size exceeds DATA_BYTES; otherwise the frame goes at the current
//   data offset, or at zero when it would reach the end of the buffer.
//   a pop fails when the oldest slot is empty.
// timing
//   write or failed request: the request is captured in the item register
//   and its result then loaded into the output register. successful pop:
//   the registered read port of the descriptor store lies between the two.
//   one request is in work at a time; the sequencer sets this order.
// reset and stalls
//   rst (synchronous) empties every slot and clears both pointers and the
//   data offset; no clearing pass is needed. while m_tready is low a result
//   waits in the output register; the next request is still taken and its
//   result is held back until that transfer completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frame_descriptor_ring_buffer #(
  parameter int SLOTS      = fdrb_pkg::SLOTS_DEF,
  parameter int DATA_BYTES = fdrb_pkg::DATA_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // media_type, stream_id, data_size, frame_id, ssrc, key_frame, height, width
  input  wire logic [fdrb_pkg::IN_TDATA_W-1:0]  s_tdata,
  // op
  input  wire logic                             s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // start_offset, out_media_type, out_stream_id, out_size, out_frame_id,
  // out_ssrc, out_key_frame, out_height, out_width
  output logic      [fdrb_pkg::OUT_TDATA_W-1:0] m_tdata,
  // ok
  output logic                                  m_tuser
);

  fdrb_pkg::cmd_t    cmd;
  fdrb_pkg::status_t sts;

  // sequencer: one request from acceptance to result
  fdrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // pointers, used flags, allocator, descriptor store and result register
  fdrb_datapath #(
    .SLOTS      (SLOTS),
    .DATA_BYTES (DATA_BYTES)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the frame descriptor ring: requests go in at random
// pace with random result back-pressure, a scoreboard class tracks slot
// occupancy, pointers and the data offset and checks every result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import fdrb_pkg::*;

  localparam int NUM_SLOTS  = SLOTS_DEF;
  localparam int DATA_SPACE = DATA_BYTES_DEF;
  localparam int RANDOM_REQ = 1700;
  localparam int SIZE_MAX   = (1 << SIZE_W) - 1;

  // expected result of one request: ok flag and output payload
  typedef struct packed {
    logic      ok;
    out_item_t body;
  } ring_result_t;

  // models the descriptor ring and holds the results still to come
  class frame_ring_scoreboard;
    bit            slot_busy [NUM_SLOTS];
    out_item_t     slot_entry [NUM_SLOTS];
    int unsigned   wr_ptr;
    int unsigned   rd_ptr;
    int unsigned   alloc_offset;
    ring_result_t  expected_q [$];
    int unsigned   mismatches;
    int unsigned   results_seen;

    function new();
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      wr_ptr       = 0;
      rd_ptr       = 0;
      alloc_offset = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // called for every accepted request transfer
    function void note_request(op_t op, in_item_t req);
      ring_result_t exp_res;
      int unsigned  start;
      exp_res = '0;
      if (op == OP_WRITE) begin
        if (!slot_busy[wr_ptr] && req.data_size <= DATA_SPACE) begin
          // strictly below the end, otherwise the frame wraps to zero
          if (alloc_offset + req.data_size < DATA_SPACE) begin
            start = alloc_offset;
            alloc_offset = alloc_offset + req.data_size;
          end else begin
            start = 0;
            alloc_offset = req.data_size;
          end
          slot_busy[wr_ptr]                = 1'b1;
          slot_entry[wr_ptr].start_offset   = start[START_W-1:0];
          slot_entry[wr_ptr].out_media_type = req.media_type;
          slot_entry[wr_ptr].out_stream_id  = req.stream_id;
          slot_entry[wr_ptr].out_size       = req.data_size;
          slot_entry[wr_ptr].out_frame_id   = req.frame_id;
          slot_entry[wr_ptr].out_ssrc       = req.ssrc;
          slot_entry[wr_ptr].out_key_frame  = req.key_frame;
          slot_entry[wr_ptr].out_height     = req.height;
          slot_entry[wr_ptr].out_width      = req.width;
          wr_ptr = (wr_ptr + 1) % NUM_SLOTS;
          exp_res.ok                = 1'b1;
          exp_res.body.start_offset = start[START_W-1:0];
        end
      end else if (slot_busy[rd_ptr]) begin
        exp_res.ok   = 1'b1;
        exp_res.body = slot_entry[rd_ptr];
        slot_busy[rd_ptr] = 1'b0;
        rd_ptr = (rd_ptr + 1) % NUM_SLOTS;
      end
      expected_q.push_back(exp_res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t mismatch on result %0d: %s", $realtime, results_seen, msg);
    endtask

    task check_field(string name, longint unsigned got, longint unsigned want);
      if (got != want)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // called for every accepted result transfer
    task check_result(logic ok, out_item_t body);
      ring_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        check_field("ok", ok, want.ok);
        check_field("start_offset", body.start_offset, want.body.start_offset);
        check_field("media_type", body.out_media_type, want.body.out_media_type);
        check_field("stream_id", body.out_stream_id, want.body.out_stream_id);
        check_field("size", body.out_size, want.body.out_size);
        check_field("frame_id", body.out_frame_id, want.body.out_frame_id);
        check_field("ssrc", body.out_ssrc, want.body.out_ssrc);
        check_field("key_frame", body.out_key_frame, want.body.out_key_frame);
        check_field("height", body.out_height, want.body.out_height);
        check_field("width", body.out_width, want.body.out_width);
      end
      results_seen++;
    endtask
  endclass

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tuser  = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  frame_ring_scoreboard sb = new();

  // pacing controls, changed per phase by the stimulus
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int stall_left = 0;

  frame_descriptor_ring_buffer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, out_item_t'(m_tdata[$bits(out_item_t)-1:0]));
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
      stall_left <= idle_len(1'b0);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic in_item_t random_frame(logic [SIZE_W-1:0] size);
    in_item_t f;
    case ($urandom_range(0, 15))
      0: f = '0;
      1: f = '1;
      default: begin
        f.media_type = 8'($urandom);
        f.stream_id  = 8'($urandom);
        f.frame_id   = $urandom;
        f.ssrc       = $urandom;
        f.key_frame  = 1'($urandom);
        f.height     = 16'($urandom);
        f.width      = 16'($urandom);
      end
    endcase
    f.data_size = size;
    return f;
  endfunction

  // size mix aimed at the wrap boundary and the size limit
  function automatic logic [SIZE_W-1:0] pick_size(int unsigned offset);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return SIZE_W'($urandom_range(0, 4096));
    if (r < 60) return SIZE_W'($urandom_range(0, DATA_SPACE / 4));
    if (r < 72) return SIZE_W'($urandom_range(0, DATA_SPACE));
    if (r < 80) return SIZE_W'(DATA_SPACE - offset);
    if (r < 86) return SIZE_W'((offset < DATA_SPACE) ? DATA_SPACE - offset - 1 : 0);
    if (r < 90) return SIZE_W'(DATA_SPACE);
    if (r < 96) return SIZE_W'($urandom_range(DATA_SPACE + 1, SIZE_MAX));
    return '0;
  endfunction

  // one request transfer, followed by an optional idle gap
  task automatic send_request(op_t op, in_item_t req);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_TDATA_W - $bits(in_item_t)){1'b0}}, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(op, req);
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_frame(logic [SIZE_W-1:0] size);
    send_request(OP_WRITE, random_frame(size));
  endtask

  task automatic read_frame();
    send_request(OP_READ, random_frame(SIZE_W'($urandom)));
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int burst;
    int kind;
    bit paused;
    in_item_t f;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty read, size extremes, exact wrap boundary, drain to empty
    read_frame();
    f = '0;
    send_request(OP_WRITE, f);
    f = '1;
    f.data_size = SIZE_W'(DATA_SPACE);
    send_request(OP_WRITE, f);
    write_frame(SIZE_W'(DATA_SPACE + 1));
    write_frame(SIZE_W'(SIZE_MAX));
    write_frame(SIZE_W'(1000));
    write_frame(SIZE_W'(DATA_SPACE - 1000));
    write_frame(SIZE_W'(999));
    repeat (6) read_frame();

    // random: write and read bursts long enough to fill and empty the ring
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_REQ) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      rx_calm = ($urandom_range(0, 5) == 0);
      kind    = $urandom_range(0, 9);
      burst   = $urandom_range(1, 22);
      for (int i = 0; i < burst; i++) begin
        if (kind < 4 || (kind >= 8 && $urandom_range(0, 1) == 0))
          write_frame(pick_size(sb.alloc_offset));
        else
          read_frame();
      end
      sent += burst;
      // hold the request side until every result is back
      if (!paused && sent > RANDOM_REQ / 2) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        drain_results();
      end
    end
    s_tvalid <= 1'b0;

    drain_results();
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[frame_descriptor_ring_buffer] OK");
    end else begin
      $display("[frame_descriptor_ring_buffer] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[frame_descriptor_ring_buffer] ERROR");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/fdrb_pkg.sv
hw/rtl/fdrb_ram.sv
hw/rtl/fdrb_ctrl.sv
hw/rtl/fdrb_datapath.sv
hw/rtl/frame_descriptor_ring_buffer.sv
tb/sv/tb.sv
